// File: rtl/atlas_grid_rect_allocator_core_defines.svh
// Assertion macros used by the atlas allocator datapath.
`ifndef ATLAS_GRID_RECT_ALLOCATOR_CORE_DEFINES_SVH
`define ATLAS_GRID_RECT_ALLOCATOR_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define AGRA_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define AGRA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define AGRA_ASSERT_IMPL(lbl, ante, cons, msg)
`define AGRA_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// File: rtl/agra_pkg.sv
// Shared constants, command codes and control structs of the atlas allocator.
`timescale 1ns / 1ps
package agra_pkg;
    localparam int MAX_REGIONS = 256;
    localparam int MAX_DIM     = 4096;
    localparam int DIM_W  = 13;
    localparam int POS_W  = 12;
    localparam int IDX_W  = $clog2(MAX_REGIONS);
    localparam int CNT_W  = IDX_W + 1;
    localparam int FREE_W = 25;
    localparam int AREA_W = 2 * DIM_W;
    localparam int CELL_W = AREA_W + 1;
    localparam int ROW_W  = DIM_W + 1;
    localparam int BOX_W  = 4 * DIM_W;

    localparam logic [DIM_W-1:0] ATLAS_RESET_DIM = DIM_W'(1024);
    localparam logic [DIM_W-1:0] MAX_DIM_V       = DIM_W'(MAX_DIM);

    localparam logic REG_ATLAS_WIDTH  = 1'b0;
    localparam logic REG_ATLAS_HEIGHT = 1'b1;

    localparam logic CMD_PLACE_RECT  = 1'b0;
    localparam logic CMD_CLEAR_ATLAS = 1'b1;

    typedef logic [4:0] dp_op_t;
    localparam dp_op_t OP_NOP       = 5'd0;
    localparam dp_op_t OP_LOAD      = 5'd1;
    localparam dp_op_t OP_PROD      = 5'd2;
    localparam dp_op_t OP_CLEAR     = 5'd3;
    localparam dp_op_t OP_FAIL      = 5'd4;
    localparam dp_op_t OP_FULL      = 5'd5;
    localparam dp_op_t OP_ROW_INIT  = 5'd6;
    localparam dp_op_t OP_COL_INIT  = 5'd7;
    localparam dp_op_t OP_NEXT_ROW  = 5'd8;
    localparam dp_op_t OP_REG_INIT  = 5'd9;
    localparam dp_op_t OP_RD        = 5'd10;
    localparam dp_op_t OP_NEXT_REG  = 5'd11;
    localparam dp_op_t OP_STEP      = 5'd12;
    localparam dp_op_t OP_DIV_START = 5'd13;
    localparam dp_op_t OP_SKIP_U    = 5'd14;
    localparam dp_op_t OP_SKIP_MUL  = 5'd15;
    localparam dp_op_t OP_SKIP_R    = 5'd16;
    localparam dp_op_t OP_PLACE     = 5'd17;
    localparam dp_op_t OP_EMIT      = 5'd18;

    typedef struct packed {
        dp_op_t op;
    } agra_cmd_t;

    typedef struct packed {
        logic is_clear;
        logic area_gt_free;
        logic store_full;
        logic row_out;
        logic col_out;
        logic count_zero;
        logic last_region;
        logic hit;
        logic skip_ok;
        logic w_zero;
        logic h_zero;
        logic div_done;
        logic out_busy;
    } agra_status_t;
endpackage

// File: rtl/agra_div.sv
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module agra_div (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [agra_pkg::POS_W-1:0]      num,
    input  logic [agra_pkg::DIM_W-1:0]      den,
    output logic                            busy,
    output logic [agra_pkg::POS_W-1:0]      quo
);
    logic [agra_pkg::DIM_W-1:0] rem_reg, rem_next;
    logic [agra_pkg::POS_W-1:0] quo_reg, quo_next;
    logic [agra_pkg::DIM_W-1:0] den_reg;
    logic [3:0]                 cnt_reg, cnt_next;
    logic                       busy_reg, busy_next;
    logic [agra_pkg::DIM_W:0]   trial;

    assign trial = {rem_reg, quo_reg[agra_pkg::POS_W-1]};

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            rem_next  = '0;
            quo_next  = num;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = agra_pkg::DIM_W'(trial - {1'b0, den_reg});
                quo_next = {quo_reg[agra_pkg::POS_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[agra_pkg::DIM_W-1:0];
                quo_next = {quo_reg[agra_pkg::POS_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 4'd1;
            if (cnt_reg == 4'(agra_pkg::POS_W - 1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (start)
        begin
            den_reg <= den;
        end
    end

    assign busy = busy_reg;
    assign quo  = quo_reg;
endmodule

// File: rtl/agra_dp.sv
// Datapath: configuration, cell registers, region memory, divider and result registers.
`timescale 1ns / 1ps
`include "atlas_grid_rect_allocator_core_defines.svh"
module agra_dp (
    input  logic                            clk,
    input  logic                            rst_n,
    input  agra_pkg::agra_cmd_t             ctl,
    output agra_pkg::agra_status_t          sts,
    input  logic                            cfg_we,
    input  logic                            cfg_addr,
    input  logic [agra_pkg::DIM_W-1:0]      cfg_wdata,
    input  logic                            cmd,
    input  logic [agra_pkg::DIM_W-1:0]      img_width,
    input  logic [agra_pkg::DIM_W-1:0]      img_height,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic                            placed,
    output logic                            store_full,
    output logic [agra_pkg::POS_W-1:0]      pos_left,
    output logic [agra_pkg::POS_W-1:0]      pos_top
);
    localparam int DW = agra_pkg::DIM_W;
    localparam int CW = agra_pkg::CELL_W;
    localparam int RW = agra_pkg::ROW_W;

    logic [DW-1:0] aw_cfg_reg, ah_cfg_reg, aw, ah;
    logic          cmd_reg;
    logic [DW-1:0] w_reg, h_reg;
    logic [agra_pkg::AREA_W-1:0] prod_reg;
    logic [agra_pkg::FREE_W-1:0] free_reg;
    logic [agra_pkg::CNT_W-1:0]  count_reg;
    logic [agra_pkg::IDX_W-1:0]  idx_reg;
    logic [DW-1:0] u_reg;
    logic [CW-1:0] left_reg, right_reg;
    logic [RW-1:0] top_reg, bottom_reg;
    logic [agra_pkg::BOX_W-1:0] mem [0:agra_pkg::MAX_REGIONS-1];
    logic [agra_pkg::BOX_W-1:0] rd_reg;
    logic [DW-1:0] s_left, s_top, s_right, s_bottom;
    logic          res_placed_reg, res_full_reg;
    logic [agra_pkg::POS_W-1:0] res_left_reg, res_top_reg;
    logic          div_busy;
    logic [agra_pkg::POS_W-1:0] div_quo;
    logic [DW-1:0] mul_a, mul_b;

    assign aw = (aw_cfg_reg > agra_pkg::MAX_DIM_V) ? agra_pkg::MAX_DIM_V : aw_cfg_reg;
    assign ah = (ah_cfg_reg > agra_pkg::MAX_DIM_V) ? agra_pkg::MAX_DIM_V : ah_cfg_reg;

    assign {s_left, s_top, s_right, s_bottom} = rd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            aw_cfg_reg <= agra_pkg::ATLAS_RESET_DIM;
            ah_cfg_reg <= agra_pkg::ATLAS_RESET_DIM;
        end
        else if (cfg_we)
        begin
            if (cfg_addr == agra_pkg::REG_ATLAS_WIDTH)
            begin
                aw_cfg_reg <= cfg_wdata;
            end
            else
            begin
                ah_cfg_reg <= cfg_wdata;
            end
        end
    end

    agra_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (ctl.op == agra_pkg::OP_DIV_START),
        .num   (agra_pkg::POS_W'(s_right - 1'b1)),
        .den   (right_reg[DW-1:0]),
        .busy  (div_busy),
        .quo   (div_quo)
    );

    // One shared multiplier: area or atlas size, and the cell position after a skip.
    always_comb
    begin
        mul_a = w_reg;
        mul_b = h_reg;
        if (ctl.op == agra_pkg::OP_SKIP_MUL)
        begin
            mul_a = u_reg;
            mul_b = w_reg;
        end
        else if (cmd_reg == agra_pkg::CMD_CLEAR_ATLAS)
        begin
            mul_a = aw;
            mul_b = ah;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            free_reg  <= agra_pkg::FREE_W'(32'(agra_pkg::ATLAS_RESET_DIM)
                         * 32'(agra_pkg::ATLAS_RESET_DIM));
            out_valid <= 1'b0;
        end
        else
        begin
            if (ctl.op == agra_pkg::OP_EMIT)
            begin
                out_valid <= 1'b1;
            end
            else if (out_valid && out_ready)
            begin
                out_valid <= 1'b0;
            end
            case (ctl.op)
                agra_pkg::OP_CLEAR:
                begin
                    count_reg <= '0;
                    free_reg  <= prod_reg[agra_pkg::FREE_W-1:0];
                end
                agra_pkg::OP_PLACE:
                begin
                    count_reg <= count_reg + 1'b1;
                    free_reg  <= free_reg - prod_reg[agra_pkg::FREE_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (ctl.op)
            agra_pkg::OP_LOAD:
            begin
                cmd_reg <= cmd;
                w_reg   <= img_width;
                h_reg   <= img_height;
            end
            agra_pkg::OP_PROD:
            begin
                prod_reg <= mul_a * mul_b;
            end
            agra_pkg::OP_CLEAR, agra_pkg::OP_FAIL:
            begin
                res_placed_reg <= 1'b0;
                res_full_reg   <= 1'b0;
                res_left_reg   <= '0;
                res_top_reg    <= '0;
            end
            agra_pkg::OP_FULL:
            begin
                res_placed_reg <= 1'b0;
                res_full_reg   <= 1'b1;
                res_left_reg   <= '0;
                res_top_reg    <= '0;
            end
            agra_pkg::OP_ROW_INIT:
            begin
                top_reg    <= '0;
                bottom_reg <= RW'(h_reg);
            end
            agra_pkg::OP_COL_INIT:
            begin
                u_reg     <= '0;
                left_reg  <= '0;
                right_reg <= CW'(w_reg);
            end
            agra_pkg::OP_NEXT_ROW:
            begin
                top_reg    <= bottom_reg;
                bottom_reg <= bottom_reg + RW'(h_reg);
            end
            agra_pkg::OP_REG_INIT:
            begin
                idx_reg <= '0;
            end
            agra_pkg::OP_RD:
            begin
                rd_reg <= mem[idx_reg];
            end
            agra_pkg::OP_NEXT_REG:
            begin
                idx_reg <= idx_reg + 1'b1;
            end
            agra_pkg::OP_STEP:
            begin
                u_reg     <= u_reg + 1'b1;
                left_reg  <= right_reg;
                right_reg <= right_reg + CW'(w_reg);
            end
            agra_pkg::OP_SKIP_U:
            begin
                u_reg <= u_reg + DW'(div_quo) + 1'b1;
            end
            agra_pkg::OP_SKIP_MUL:
            begin
                left_reg <= CW'(mul_a * mul_b);
            end
            agra_pkg::OP_SKIP_R:
            begin
                right_reg <= left_reg + CW'(w_reg);
            end
            agra_pkg::OP_PLACE:
            begin
                mem[count_reg[agra_pkg::IDX_W-1:0]] <= {left_reg[DW-1:0], top_reg[DW-1:0],
                                                       right_reg[DW-1:0], bottom_reg[DW-1:0]};
                res_placed_reg <= 1'b1;
                res_full_reg   <= 1'b0;
                res_left_reg   <= left_reg[agra_pkg::POS_W-1:0];
                res_top_reg    <= top_reg[agra_pkg::POS_W-1:0];
            end
            agra_pkg::OP_EMIT:
            begin
                placed     <= res_placed_reg;
                store_full <= res_full_reg;
                pos_left   <= res_left_reg;
                pos_top    <= res_top_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        sts.is_clear     = (cmd_reg == agra_pkg::CMD_CLEAR_ATLAS);
        sts.area_gt_free = prod_reg > agra_pkg::AREA_W'(free_reg);
        sts.store_full   = count_reg == agra_pkg::CNT_W'(agra_pkg::MAX_REGIONS);
        sts.row_out      = bottom_reg > RW'(ah);
        sts.col_out      = right_reg > CW'(aw);
        sts.count_zero   = count_reg == '0;
        sts.last_region  = ({1'b0, idx_reg} + 1'b1) == count_reg;
        sts.hit          = (CW'(s_left) < right_reg) && (left_reg < CW'(s_right))
                           && (RW'(s_top) < bottom_reg) && (top_reg < RW'(s_bottom));
        sts.skip_ok      = (CW'(s_right) > right_reg) && (right_reg != '0);
        sts.w_zero       = w_reg == '0;
        sts.h_zero       = h_reg == '0;
        sts.div_done     = !div_busy;
        sts.out_busy     = out_valid && !out_ready;
    end

    `AGRA_ASSERT_IMPL(a_place_room, ctl.op == agra_pkg::OP_PLACE, !sts.store_full, "placement into a full store")
    `AGRA_ASSERT_IMPL(a_place_area, ctl.op == agra_pkg::OP_PLACE, !sts.area_gt_free, "placement larger than free area")
    `AGRA_ASSERT_IMPL(a_skip_div, ctl.op == agra_pkg::OP_SKIP_U, !div_busy, "skip taken before divider finished")
    `AGRA_ASSERT_NEXT(a_emit_valid, ctl.op == agra_pkg::OP_EMIT, out_valid, "result not presented after emit")
endmodule

// File: rtl/agra_ctrl.sv
// Controller state machine sequencing the scan over grid cells and stored regions.
`timescale 1ns / 1ps
module agra_ctrl (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  agra_pkg::agra_status_t      sts,
    output agra_pkg::agra_cmd_t         ctl
);
    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_PROD     = 4'd1;
    localparam logic [3:0] S_DECIDE   = 4'd2;
    localparam logic [3:0] S_ROW_CHK  = 4'd3;
    localparam logic [3:0] S_COL_CHK  = 4'd4;
    localparam logic [3:0] S_NEXT_ROW = 4'd5;
    localparam logic [3:0] S_REG_RD   = 4'd6;
    localparam logic [3:0] S_REG_CMP  = 4'd7;
    localparam logic [3:0] S_STEP     = 4'd8;
    localparam logic [3:0] S_DIV      = 4'd9;
    localparam logic [3:0] S_SKIP_MUL = 4'd10;
    localparam logic [3:0] S_SKIP_R   = 4'd11;
    localparam logic [3:0] S_PLACE    = 4'd12;
    localparam logic [3:0] S_FAIL     = 4'd13;
    localparam logic [3:0] S_EMIT     = 4'd14;

    logic [3:0] state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        ctl.op     = agra_pkg::OP_NOP;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    ctl.op     = agra_pkg::OP_LOAD;
                    state_next = S_PROD;
                end
            end
            S_PROD:
            begin
                ctl.op     = agra_pkg::OP_PROD;
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                if (sts.is_clear)
                begin
                    ctl.op     = agra_pkg::OP_CLEAR;
                    state_next = S_EMIT;
                end
                else if (sts.area_gt_free)
                begin
                    ctl.op     = agra_pkg::OP_FAIL;
                    state_next = S_EMIT;
                end
                else if (sts.store_full)
                begin
                    ctl.op     = agra_pkg::OP_FULL;
                    state_next = S_EMIT;
                end
                else
                begin
                    ctl.op     = agra_pkg::OP_ROW_INIT;
                    state_next = S_ROW_CHK;
                end
            end
            S_ROW_CHK:
            begin
                ctl.op     = agra_pkg::OP_COL_INIT;
                state_next = sts.row_out ? S_FAIL : S_COL_CHK;
            end
            S_COL_CHK:
            begin
                ctl.op = agra_pkg::OP_REG_INIT;
                if (sts.col_out)
                begin
                    state_next = S_NEXT_ROW;
                end
                else if (sts.count_zero)
                begin
                    state_next = S_PLACE;
                end
                else
                begin
                    state_next = S_REG_RD;
                end
            end
            S_NEXT_ROW:
            begin
                // A zero-height rectangle only ever tries the first row.
                if (sts.h_zero)
                begin
                    state_next = S_FAIL;
                end
                else
                begin
                    ctl.op     = agra_pkg::OP_NEXT_ROW;
                    state_next = S_ROW_CHK;
                end
            end
            S_REG_RD:
            begin
                ctl.op     = agra_pkg::OP_RD;
                state_next = S_REG_CMP;
            end
            S_REG_CMP:
            begin
                if (sts.hit)
                begin
                    if (sts.skip_ok)
                    begin
                        ctl.op     = agra_pkg::OP_DIV_START;
                        state_next = S_DIV;
                    end
                    else
                    begin
                        state_next = S_STEP;
                    end
                end
                else if (sts.last_region)
                begin
                    state_next = S_PLACE;
                end
                else
                begin
                    ctl.op     = agra_pkg::OP_NEXT_REG;
                    state_next = S_REG_RD;
                end
            end
            S_STEP:
            begin
                if (sts.w_zero)
                begin
                    state_next = S_NEXT_ROW;
                end
                else
                begin
                    ctl.op     = agra_pkg::OP_STEP;
                    state_next = S_COL_CHK;
                end
            end
            S_DIV:
            begin
                if (sts.div_done)
                begin
                    ctl.op     = agra_pkg::OP_SKIP_U;
                    state_next = S_SKIP_MUL;
                end
            end
            S_SKIP_MUL:
            begin
                ctl.op     = agra_pkg::OP_SKIP_MUL;
                state_next = S_SKIP_R;
            end
            S_SKIP_R:
            begin
                ctl.op     = agra_pkg::OP_SKIP_R;
                state_next = S_COL_CHK;
            end
            S_PLACE:
            begin
                ctl.op     = agra_pkg::OP_PLACE;
                state_next = S_EMIT;
            end
            S_FAIL:
            begin
                ctl.op     = agra_pkg::OP_FAIL;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (!sts.out_busy)
                begin
                    ctl.op     = agra_pkg::OP_EMIT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);
endmodule

// File: rtl/atlas_grid_rect_allocator_core.sv
// Top level of the atlas rectangle allocator.
`timescale 1ns / 1ps
// Each input transfer either clears the atlas or places a rectangle by scanning grid cells of
// the rectangle's own size, row by row, and testing each cell against the stored regions in
// insertion order; one result transfer follows each input transfer. A clear or an early
// failure passes the load, product, decide and emit states, waiting in emit while the
// output is busy. A placement adds the row check and place states, a column check state for
// each cell tested with a read and a compare state for each stored region it is compared
// with, a step state past a blocked cell or the divide, skip multiply and skip right states
// for a column skip, and next-row and row check states for each move to the next row. The
// region memory is single-port and the bit-serial divider computes the skip distance. The
// next input transfer is taken while the previous result still waits at the output register.
module atlas_grid_rect_allocator_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic                            cfg_addr,
    input  logic [agra_pkg::DIM_W-1:0]      cfg_wdata,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            cmd,
    input  logic [agra_pkg::DIM_W-1:0]      img_width,
    input  logic [agra_pkg::DIM_W-1:0]      img_height,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic                            placed,
    output logic                            store_full,
    output logic [agra_pkg::POS_W-1:0]      pos_left,
    output logic [agra_pkg::POS_W-1:0]      pos_top
);
    agra_pkg::agra_cmd_t    ctl;
    agra_pkg::agra_status_t sts;

    agra_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .ctl      (ctl)
    );

    agra_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .sts        (sts),
        .cfg_we     (cfg_we),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .cmd        (cmd),
        .img_width  (img_width),
        .img_height (img_height),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .placed     (placed),
        .store_full (store_full),
        .pos_left   (pos_left),
        .pos_top    (pos_top)
    );
endmodule
